// ===== design/bounded_double_ended_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Deque assertion macros
// Concurrent assertion wrappers on clk, with or without the reset guard.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define BDQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BDQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDQ_ASSERT(label, prop, msg)
`define BDQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, request codes and cell control type of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

	localparam int DEPTH     = 64;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CAP_W     = 7;
	localparam int REQ_W     = 3;
	localparam int S_TDATA_W = ((REQ_W + DATA_W + 7) / 8) * 8;
	localparam int M_RES_W   = 1 + DATA_W + DATA_W + 1 + 1;
	localparam int M_TDATA_W = ((M_RES_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
	localparam logic [DATA_W-1:0] EMPTY_VAL = '1;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_QUERY      = 3'd4
	} req_t;

	// row-wide moves, same for every cell
	typedef struct packed {
		logic shift_back;  // push front: each cell takes its front neighbor
		logic shift_fwd;   // pop front: each cell takes its back neighbor
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// bdq_cell
// One deque slot: holds an entry, trades it with its neighbors on a shift,
// and drives its entry onto the rear bus when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell (
	input  wire logic                      clk,
	input  wire bdq_pkg::cell_ctl_t        ctl,
	input  wire logic                      wr_back,    // push back lands here
	input  wire logic [bdq_pkg::DATA_W-1:0] value,
	input  wire logic [bdq_pkg::DATA_W-1:0] front_data, // neighbor toward front
	input  wire logic [bdq_pkg::DATA_W-1:0] back_data,  // neighbor toward back
	input  wire logic                      rear_sel,
	output logic      [bdq_pkg::DATA_W-1:0] data,
	output logic      [bdq_pkg::DATA_W-1:0] rear_term
);
	import bdq_pkg::*;

	logic [DATA_W-1:0] data_q;

	// entry register, payload only
	always_ff @(posedge clk) begin
		if (ctl.shift_back) begin
			data_q <= front_data;
		end else if (ctl.shift_fwd) begin
			data_q <= back_data;
		end else if (wr_back) begin
			data_q <= value;
		end
	end

	assign data      = data_q;
	assign rear_term = rear_sel ? data_q : '0;

endmodule

`default_nettype wire

// ===== design/bounded_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed 32-bit values held in a row of shifting cells;
// cell 0 is always the front, cell count-1 the rear.
// ----------------------------------------------------------------------------
//
//  port group   | dir | moves
//  -------------+-----+-----------------------------------------------
//  s_axis_*     | in  | request: req_type, value
//  m_axis_*     | out | result: ok, front, rear, empty, full
//  cfg_*        | in  | capacity write, one register
//
//  One request per cycle: the next state and the result are formed in the
//  same cycle the request is taken, and the result sits in one output
//  register. A push front or pop front moves the whole row of cells by one.
//  Input is taken whenever the output register is empty or being drained,
//  so a stalled result holds the input off. Reset clears the count and sets
//  capacity to 64; cell contents are not reset and are never read unwritten.
//
`default_nettype none

`include "bounded_double_ended_queue_assert.svh"

module bounded_double_ended_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// req_type [2:0], value [34:3], zero pad above
	input  wire logic [bdq_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// ok [0], front_value [32:1], rear_value [64:33], is_empty [65],
	// is_full [66], zero pad above
	output logic      [bdq_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	input  wire logic                         cfg_we,
	input  wire logic [bdq_pkg::CAP_W-1:0]     cfg_wdata
);
	import bdq_pkg::*;

	localparam int NEXT_IDX = (DEPTH > 1) ? 1 : 0;

	logic [CAP_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic              ok_q;
	logic [DATA_W-1:0] front_q;
	logic [DATA_W-1:0] rear_q;
	logic              empty_q;
	logic              full_q;

	logic              accept;
	logic [REQ_W-1:0]  req_raw;
	logic [DATA_W-1:0] req_value;
	logic [CNT_W-1:0]  limit;
	logic              can_push;
	logic              can_pop;
	logic              do_push_front;
	logic              do_push_back;
	logic              do_pop_front;
	logic              do_pop_back;
	logic              ok_next;
	logic [CNT_W-1:0]  count_next;
	logic [DATA_W-1:0] front_next;
	logic [DATA_W-1:0] rear_next;
	logic [DATA_W-1:0] rear_bus;
	cell_ctl_t         ctl;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] rear_term [DEPTH];
	logic [DEPTH-1:0]  wr_back;
	logic [DEPTH-1:0]  rear_sel;

	// request fields
	assign req_raw   = s_axis_tdata[REQ_W-1:0];
	assign req_value = s_axis_tdata[REQ_W +: DATA_W];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// effective limit: smaller of capacity and depth
	always_comb begin
		if (32'(capacity_q) >= DEPTH) begin
			limit = CNT_W'(DEPTH);
		end else begin
			limit = CNT_W'(capacity_q);
		end
	end

	assign can_push = count_q < limit;
	assign can_pop  = count_q != '0;

	// decode
	always_comb begin
		do_push_front = 1'b0;
		do_push_back  = 1'b0;
		do_pop_front  = 1'b0;
		do_pop_back   = 1'b0;
		ok_next       = 1'b1;
		case (req_raw)
			REQ_PUSH_FRONT: begin
				do_push_front = can_push;
				ok_next       = can_push;
			end
			REQ_PUSH_BACK: begin
				do_push_back = can_push;
				ok_next      = can_push;
			end
			REQ_POP_FRONT: begin
				do_pop_front = can_pop;
				ok_next      = can_pop;
			end
			REQ_POP_BACK: begin
				do_pop_back = can_pop;
				ok_next     = can_pop;
			end
			default: begin
				ok_next = 1'b1;
			end
		endcase
	end

	// count after the step
	always_comb begin
		count_next = count_q;
		if (do_push_front || do_push_back) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_pop_front || do_pop_back) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign ctl.shift_back = accept && do_push_front;
	assign ctl.shift_fwd  = accept && do_pop_front;

	// row of cells, each wired to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] from_front;
		logic [DATA_W-1:0] from_back;

		if (i == 0) begin : g_head
			assign from_front = req_value;
		end else begin : g_mid
			assign from_front = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign from_back   = '0;
			assign rear_sel[i] = !do_pop_back && (count_q == CNT_W'(i + 1));
		end else begin : g_body
			assign from_back   = cell_data[i+1];
			assign rear_sel[i] = do_pop_back ? (count_q == CNT_W'(i + 2))
			                                 : (count_q == CNT_W'(i + 1));
		end

		assign wr_back[i] = accept && do_push_back && (count_q == CNT_W'(i));

		bdq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.wr_back    (wr_back[i]),
			.value      (req_value),
			.front_data (from_front),
			.back_data  (from_back),
			.rear_sel   (rear_sel[i]),
			.data       (cell_data[i]),
			.rear_term  (rear_term[i])
		);
	end

	// one-hot rear pick across the row
	always_comb begin
		rear_bus = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_bus = rear_bus | rear_term[i];
		end
	end

	// front and rear after the step
	always_comb begin
		if (count_next == '0) begin
			front_next = EMPTY_VAL;
		end else if (do_push_front || (do_push_back && count_q == '0)) begin
			front_next = req_value;
		end else if (do_pop_front) begin
			front_next = cell_data[NEXT_IDX];
		end else begin
			front_next = cell_data[0];
		end
	end

	always_comb begin
		if (count_next == '0) begin
			rear_next = EMPTY_VAL;
		end else if (do_push_back || (do_push_front && count_q == '0)) begin
			rear_next = req_value;
		end else begin
			rear_next = rear_bus;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= ok_next;
			front_q <= front_next;
			rear_q  <= rear_next;
			empty_q <= count_next == '0;
			full_q  <= count_next >= limit;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'({full_q, empty_q, rear_q, front_q, ok_q});

	`BDQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "count beyond depth")
	`BDQ_ASSERT(a_empty_flag, out_valid_q |-> (empty_q == (count_q == '0)), "empty flag off count")
	`BDQ_ASSERT(a_front_cell, (out_valid_q && !empty_q) |-> (front_q == cell_data[0]), "front not cell 0")
	`BDQ_ASSERT(a_fail_hold, (accept && !ok_next) |=> $stable(count_q), "failed request moved count")
	`BDQ_ASSERT(a_push_count, (accept && (do_push_front || do_push_back)) |=> (count_q == $past(count_q) + CNT_W'(1)), "push did not grow count")

endmodule

`default_nettype wire
